@@ hdl/autorange_period_frequency_meter_unit_assert.svh @@
// Assertion helpers shared by the meter RTL. Clock aclk, reset aresetn.
`ifndef AUTORANGE_PERIOD_FREQUENCY_METER_UNIT_ASSERT_SVH
`define AUTORANGE_PERIOD_FREQUENCY_METER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define APFM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define APFM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/apfm_pkg.sv @@
package apfm_pkg;

    localparam int TICK_W     = 20;
    localparam int THR_W      = 20;
    localparam int AVG_W      = 4;
    localparam int EDGE_W     = 5;
    localparam int FREQ_W     = 24;
    localparam int NUM_W      = TICK_W + EDGE_W;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 20;
    localparam int FLAG_W     = 3;

    localparam int TIMER_WIDTH_DEF = 16;
    localparam int MAX_AVERAGE_DEF = 8;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [FREQ_W-1:0] FREQ_MAX = 24'd16000000;

    localparam logic [CFG_ADDR_W-1:0] CFG_TICK_RATE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_AVG_COUNT = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_EDGES     = 2'd3;

    localparam logic [TICK_W-1:0] TICK_RATE_RST = 20'd500000;
    localparam logic [THR_W-1:0]  THRESHOLD_RST = 20'd1000;
    localparam logic [AVG_W-1:0]  AVG_COUNT_RST = 4'd5;
    localparam logic [EDGE_W-1:0] EDGES_RST     = 5'd16;

    typedef struct packed {
        logic [TICK_W-1:0] tick_rate_hz;
        logic [THR_W-1:0]  switch_threshold_hz;
        logic [AVG_W-1:0]  average_count;
        logic [EDGE_W-1:0] high_range_edges;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

@@ hdl/apfm_front.sv @@
module apfm_front #(
    parameter int TIMER_WIDTH = apfm_pkg::TIMER_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TIMER_WIDTH-1:0] capture_value,
    output logic                   q_push,
    output logic [TIMER_WIDTH-1:0] q_data,
    input  logic                   q_ready
);

    logic                   phase_reg;
    logic                   phase_next;
    logic [TIMER_WIDTH-1:0] first_reg;
    logic [TIMER_WIDTH-1:0] first_next;
    logic                   accept;

    // first capture of a pair never needs queue space
    assign s_tready = !phase_reg || q_ready;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = accept && phase_reg;
    assign q_data   = capture_value - first_reg;   // wraps at timer width

    always_comb begin
        phase_next = phase_reg;
        first_next = first_reg;
        if (accept) begin
            phase_next = !phase_reg;
            if (!phase_reg) begin
                first_next = capture_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
        end
        first_reg <= first_next;
    end

endmodule

@@ hdl/apfm_queue.sv @@
module apfm_queue #(
    parameter int WIDTH = apfm_pkg::TIMER_WIDTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             ready,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] dout
);

    localparam int DEPTH = apfm_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign ready   = count_reg != CNT_W'(DEPTH);
    assign valid   = count_reg != '0;
    assign dout    = mem_reg[rd_ptr_reg];
    assign do_push = push && ready;
    assign do_pop  = pop && valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

@@ hdl/apfm_div.sv @@
module apfm_div #(
    parameter int DVD_W = 25,
    parameter int DSR_W = 19
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [DVD_W-1:0]    dividend,
    input  logic [DSR_W-1:0]    divisor,
    output apfm_pkg::div_stat_t stat,
    output logic [DVD_W-1:0]    quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DSR_W-1:0] rem_reg;
    logic [DSR_W-1:0] rem_next;
    logic [DVD_W-1:0] quo_reg;
    logic [DVD_W-1:0] quo_next;
    logic [DSR_W-1:0] den_reg;
    logic [DSR_W-1:0] den_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [DSR_W:0]   rem_sh;
    logic [DSR_W+1:0] diff;

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

    // restoring division, one quotient bit per cycle, MSB first
    assign rem_sh = {rem_reg, quo_reg[DVD_W-1]};
    assign diff   = {1'b0, rem_sh} - (DSR_W + 2)'(den_reg);

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
            cnt_next  = CNT_W'(DVD_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = diff[DSR_W+1] ? rem_sh[DSR_W-1:0] : diff[DSR_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], ~diff[DSR_W+1]};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

endmodule

@@ hdl/apfm_back.sv @@
module apfm_back #(
    parameter int TIMER_WIDTH = apfm_pkg::TIMER_WIDTH_DEF,
    parameter int MAX_AVERAGE = apfm_pkg::MAX_AVERAGE_DEF,
    parameter int SUM_W       = TIMER_WIDTH + $clog2(MAX_AVERAGE),
    parameter int DVD_W       = (apfm_pkg::NUM_W > SUM_W) ? apfm_pkg::NUM_W : SUM_W
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  apfm_pkg::cfg_t                     cfg,
    input  logic                               q_valid,
    input  logic [TIMER_WIDTH-1:0]             q_data,
    output logic                               q_pop,
    output logic                               div_start,
    output logic [DVD_W-1:0]                   div_dividend,
    output logic [SUM_W-1:0]                   div_divisor,
    input  apfm_pkg::div_stat_t                div_stat,
    input  logic [DVD_W-1:0]                   div_quo,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [apfm_pkg::FREQ_W-1:0]        m_tdata,   // frequency_hz
    output logic [apfm_pkg::FLAG_W-1:0]        m_tuser    // range_high, averaged, zero_period
);

    localparam int CNT_W = $clog2(MAX_AVERAGE + 1);
    localparam int FW    = apfm_pkg::FREQ_W;
    localparam logic [4:0] MAX_AVG5 = 5'(MAX_AVERAGE);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_AVG   = 2'd1;
    localparam logic [1:0] ST_FINAL = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    logic [1:0]                 state_reg,    state_next;
    logic                       range_reg,    range_next;
    logic [CNT_W-1:0]           count_reg,    count_next;
    logic [SUM_W-1:0]           sum_reg,      sum_next;
    logic [TIMER_WIDTH-1:0]     period_reg,   period_next;
    logic [apfm_pkg::NUM_W-1:0] num_reg,      num_next;
    logic [SUM_W-1:0]           den_reg,      den_next;
    logic                       add_reg,      add_next;
    logic                       avg_reg,      avg_next;
    logic [FW-1:0]              res_freq_reg, res_freq_next;
    logic [apfm_pkg::FLAG_W-1:0] res_flag_reg, res_flag_next;
    logic                       m_tvalid_reg, m_tvalid_next;
    logic [FW-1:0]              m_tdata_reg,  m_tdata_next;
    logic [apfm_pkg::FLAG_W-1:0] m_tuser_reg, m_tuser_next;

    logic [4:0]                 cnt5;
    logic [CNT_W-1:0]           cnt_eff;
    logic [apfm_pkg::EDGE_W-1:0] edges_eff;
    logic [apfm_pkg::NUM_W-1:0] num_comb;
    logic                       zero_c;
    logic [FW-1:0]              freq_c;
    logic                       above_c;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // clamp averaging count to 1..MAX_AVERAGE, edge count zero means one
    always_comb begin
        if (cfg.average_count == '0) begin
            cnt5 = 5'd1;
        end else if ({1'b0, cfg.average_count} > MAX_AVG5) begin
            cnt5 = MAX_AVG5;
        end else begin
            cnt5 = {1'b0, cfg.average_count};
        end
        cnt_eff   = CNT_W'(cnt5);
        edges_eff = (cfg.high_range_edges == '0) ? apfm_pkg::EDGE_W'(1) : cfg.high_range_edges;
        num_comb  = apfm_pkg::NUM_W'(cfg.tick_rate_hz) * apfm_pkg::NUM_W'(edges_eff);
    end

    // saturate the quotient; zero divisor forces full scale
    always_comb begin
        zero_c = den_reg == '0;
        if (zero_c || div_quo > DVD_W'(apfm_pkg::FREQ_MAX)) begin
            freq_c = apfm_pkg::FREQ_MAX;
        end else begin
            freq_c = div_quo[FW-1:0];
        end
        above_c = freq_c > FW'(cfg.switch_threshold_hz);
    end

    always_comb begin
        state_next    = state_reg;
        range_next    = range_reg;
        count_next    = count_reg;
        sum_next      = sum_reg;
        period_next   = period_reg;
        num_next      = num_reg;
        den_next      = den_reg;
        add_next      = add_reg;
        avg_next      = avg_reg;
        res_freq_next = res_freq_reg;
        res_flag_next = res_flag_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        q_pop         = 1'b0;
        div_start     = 1'b0;
        div_dividend  = '0;
        div_divisor   = '0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop       = 1'b1;
                    period_next = q_data;
                    num_next    = num_comb;
                    add_next    = 1'b0;
                    avg_next    = 1'b0;
                    div_start   = 1'b1;
                    if (!range_reg) begin
                        div_dividend = DVD_W'(cfg.tick_rate_hz);
                        div_divisor  = SUM_W'(q_data);
                        den_next     = SUM_W'(q_data);
                        state_next   = ST_FINAL;
                    end else if (count_reg < cnt_eff) begin
                        add_next     = 1'b1;
                        div_dividend = DVD_W'(num_comb);
                        div_divisor  = SUM_W'(q_data);
                        den_next     = SUM_W'(q_data);
                        state_next   = ST_FINAL;
                    end else begin
                        // averaged pass: first sum / count, then scale / average
                        avg_next     = 1'b1;
                        div_dividend = DVD_W'(sum_reg);
                        div_divisor  = SUM_W'(cnt_eff);
                        state_next   = ST_AVG;
                    end
                end
            end
            ST_AVG: begin
                if (div_stat.done) begin
                    den_next     = div_quo[SUM_W-1:0];
                    div_start    = 1'b1;
                    div_dividend = DVD_W'(num_reg);
                    div_divisor  = div_quo[SUM_W-1:0];
                    state_next   = ST_FINAL;
                end
            end
            ST_FINAL: begin
                if (div_stat.done) begin
                    if (!range_reg) begin
                        range_next = above_c;
                    end else begin
                        if (add_reg) begin
                            sum_next   = sum_reg + SUM_W'(period_reg);
                            count_next = count_reg + CNT_W'(1);
                        end else begin
                            sum_next   = '0;
                            count_next = '0;
                        end
                        if (!above_c) begin
                            range_next = 1'b0;
                            sum_next   = '0;
                            count_next = '0;
                        end
                    end
                    res_freq_next = freq_c;
                    res_flag_next = {zero_c, avg_reg, above_c};
                    state_next    = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_freq_reg;
                    m_tuser_next  = res_flag_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            range_reg    <= 1'b0;
            count_reg    <= '0;
            sum_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            range_reg    <= range_next;
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        period_reg   <= period_next;
        num_reg      <= num_next;
        den_reg      <= den_next;
        add_reg      <= add_next;
        avg_reg      <= avg_next;
        res_freq_reg <= res_freq_next;
        res_flag_reg <= res_flag_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

endmodule

@@ hdl/autorange_period_frequency_meter_unit.sv @@
// Autorange period/frequency meter on timer captures.
// s_ channel: one captured timer value per item. Captures pair up; the
// first of a pair is stored, the second yields the period and one result.
// m_ channel: one result item per pair, frequency in tdata, flags in tuser.
// cfg_we/cfg_addr/cfg_wdata write the four setup registers; change them only
// while no item is in flight.
// Flow: with the back end idle, the second capture's period is pushed into
// the queue and popped by the back end, which starts the divider; the
// quotient is saturated, registered and then sent out. An averaged result
// runs the divider twice. The restoring divider makes one quotient bit per
// cycle; one pair is divided at a time, the next only once the last result
// is in the output register. A two-entry period queue sits between the
// capture pairing logic and the divider, so captures keep flowing while a
// division runs or a result waits, until the queue is full.
// Output is registered: while m_tready is low the result holds and the next
// division may finish into a side register before the back end stalls.
// Reset (aresetn low, synchronous) returns to low range, clears pairing and
// the averager and loads the register defaults.
`include "autorange_period_frequency_meter_unit_assert.svh"

module autorange_period_frequency_meter_unit #(
    parameter int TIMER_WIDTH = apfm_pkg::TIMER_WIDTH_DEF,
    parameter int MAX_AVERAGE = apfm_pkg::MAX_AVERAGE_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((TIMER_WIDTH+7)/8)*8-1:0]    s_tdata,    // capture_value
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [apfm_pkg::FREQ_W-1:0]         m_tdata,    // frequency_hz
    output logic [apfm_pkg::FLAG_W-1:0]         m_tuser,    // range_high, averaged, zero_period
    input  logic                                cfg_we,
    input  logic [apfm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [apfm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int SUM_W = TIMER_WIDTH + $clog2(MAX_AVERAGE);
    localparam int DVD_W = (apfm_pkg::NUM_W > SUM_W) ? apfm_pkg::NUM_W : SUM_W;

    apfm_pkg::cfg_t      cfg_reg;
    apfm_pkg::cfg_t      cfg_next;
    logic                q_push;
    logic [TIMER_WIDTH-1:0] q_in;
    logic                q_ready;
    logic                q_pop;
    logic                q_valid;
    logic [TIMER_WIDTH-1:0] q_out;
    logic                div_start;
    logic [DVD_W-1:0]    div_dividend;
    logic [SUM_W-1:0]    div_divisor;
    apfm_pkg::div_stat_t div_stat;
    logic [DVD_W-1:0]    div_quo;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                apfm_pkg::CFG_TICK_RATE:
                    cfg_next.tick_rate_hz = cfg_wdata[apfm_pkg::TICK_W-1:0];
                apfm_pkg::CFG_THRESHOLD:
                    cfg_next.switch_threshold_hz = cfg_wdata[apfm_pkg::THR_W-1:0];
                apfm_pkg::CFG_AVG_COUNT:
                    cfg_next.average_count = cfg_wdata[apfm_pkg::AVG_W-1:0];
                apfm_pkg::CFG_EDGES:
                    cfg_next.high_range_edges = cfg_wdata[apfm_pkg::EDGE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tick_rate_hz        <= apfm_pkg::TICK_RATE_RST;
            cfg_reg.switch_threshold_hz <= apfm_pkg::THRESHOLD_RST;
            cfg_reg.average_count       <= apfm_pkg::AVG_COUNT_RST;
            cfg_reg.high_range_edges    <= apfm_pkg::EDGES_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    apfm_front #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .capture_value (s_tdata[TIMER_WIDTH-1:0]),
        .q_push        (q_push),
        .q_data        (q_in),
        .q_ready       (q_ready)
    );

    apfm_queue #(
        .WIDTH (TIMER_WIDTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_in),
        .ready   (q_ready),
        .pop     (q_pop),
        .valid   (q_valid),
        .dout    (q_out)
    );

    apfm_div #(
        .DVD_W (DVD_W),
        .DSR_W (SUM_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    apfm_back #(
        .TIMER_WIDTH (TIMER_WIDTH),
        .MAX_AVERAGE (MAX_AVERAGE),
        .SUM_W       (SUM_W),
        .DVD_W       (DVD_W)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .q_valid      (q_valid),
        .q_data       (q_out),
        .q_pop        (q_pop),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_stat     (div_stat),
        .div_quo      (div_quo),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser)
    );

    `APFM_ASSERT_IMPL(a_div_start_idle, div_start, !div_stat.busy, "divider restarted while busy")
    `APFM_ASSERT_NEXT(a_div_runs, div_start, div_stat.busy, "divider did not start")
    `APFM_ASSERT_IMPL(a_zero_sat, m_tvalid && m_tuser[2], m_tdata == apfm_pkg::FREQ_MAX, "zero period not saturated")
    `APFM_ASSERT_IMPL(a_freq_max, m_tvalid, m_tdata <= apfm_pkg::FREQ_MAX, "frequency above full scale")

endmodule
